FILE: design/pipd_pkg.sv
// Shared types, constants and codes for the pulse interval pattern detector.
`timescale 1ns / 1ps
`default_nettype none

package pipd_pkg;

  // Storage sizes
  localparam int RING_DEPTH  = 32;
  localparam int MAX_PATTERN = 32;
  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int PAT_AW      = $clog2(MAX_PATTERN);
  localparam int LEN_EFF_W   = $clog2(MAX_PATTERN + 1);

  // Field widths
  localparam int FUNC_W      = 2;
  localparam int TIME_W      = 32;
  localparam int INDEX_W     = 5;
  localparam int ENTRY_W     = 12;
  localparam int INTERVAL_W  = 10;
  localparam int SYNC_W      = 12;
  localparam int TOL_W       = 9;
  localparam int LEN_W       = 6;
  localparam int MATCH_W     = 5;
  localparam int PROD_W      = ENTRY_W + TOL_W;
  localparam int Q8_SHIFT    = 8;

  // Stream and register port widths
  localparam int S_DATA_W    = 56;
  localparam int M_DATA_W    = 8;
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 32;

  // Item kinds
  localparam logic [FUNC_W-1:0] FN_EDGE  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SCAN  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd3;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_MIN_ACCEPT = 3'd0;
  localparam logic [2:0] REG_MAX_ACCEPT = 3'd1;
  localparam logic [2:0] REG_SYNC_TIME  = 3'd2;
  localparam logic [2:0] REG_TOL_LOW    = 3'd3;
  localparam logic [2:0] REG_TOL_HIGH   = 3'd4;
  localparam logic [2:0] REG_PAT_LEN    = 3'd5;

  // Reset values
  localparam logic [INTERVAL_W-1:0] MIN_ACCEPT_RST = 10'd100;
  localparam logic [INTERVAL_W-1:0] MAX_ACCEPT_RST = 10'd1000;
  localparam logic [SYNC_W-1:0]     SYNC_TIME_RST  = 12'd500;
  localparam logic [TOL_W-1:0]      TOL_LOW_RST    = 9'd205;
  localparam logic [TOL_W-1:0]      TOL_HIGH_RST   = 9'd307;
  localparam logic [LEN_W-1:0]      PAT_LEN_RST    = 6'd8;

  typedef struct packed {
    logic [INTERVAL_W-1:0] min_accept_us;
    logic [INTERVAL_W-1:0] max_accept_us;
    logic [SYNC_W-1:0]     sync_time_us;
    logic [TOL_W-1:0]      tol_low_q8;
    logic [TOL_W-1:0]      tol_high_q8;
    logic [LEN_W-1:0]      pattern_length;
  } cfg_t;

  typedef struct packed {
    logic                  ring_we;
    logic [RING_AW-1:0]    ring_waddr;
    logic [INTERVAL_W-1:0] ring_wdata;
    logic                  pat_we;
    logic [PAT_AW-1:0]     pat_waddr;
    logic [ENTRY_W-1:0]    pat_wdata;
    logic                  rd_en;
    logic [RING_AW-1:0]    ring_raddr;
    logic [PAT_AW-1:0]     pat_raddr;
  } store_req_t;

endpackage

`default_nettype wire

FILE: design/pipd_regs.sv
// Configuration register bank behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module pipd_regs (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [pipd_pkg::APB_AW-1:0]   paddr,
  input  wire [pipd_pkg::APB_DW-1:0]   pwdata,
  output logic [pipd_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output pipd_pkg::cfg_t               cfg
);
  import pipd_pkg::*;

  logic [2:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[APB_AW-1:2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_accept_us  <= MIN_ACCEPT_RST;
      cfg.max_accept_us  <= MAX_ACCEPT_RST;
      cfg.sync_time_us   <= SYNC_TIME_RST;
      cfg.tol_low_q8     <= TOL_LOW_RST;
      cfg.tol_high_q8    <= TOL_HIGH_RST;
      cfg.pattern_length <= PAT_LEN_RST;
    end else if (wr_en) begin
      case (reg_index)
        REG_MIN_ACCEPT: cfg.min_accept_us  <= pwdata[INTERVAL_W-1:0];
        REG_MAX_ACCEPT: cfg.max_accept_us  <= pwdata[INTERVAL_W-1:0];
        REG_SYNC_TIME:  cfg.sync_time_us   <= pwdata[SYNC_W-1:0];
        REG_TOL_LOW:    cfg.tol_low_q8     <= pwdata[TOL_W-1:0];
        REG_TOL_HIGH:   cfg.tol_high_q8    <= pwdata[TOL_W-1:0];
        REG_PAT_LEN:    cfg.pattern_length <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_MIN_ACCEPT: prdata = APB_DW'(cfg.min_accept_us);
      REG_MAX_ACCEPT: prdata = APB_DW'(cfg.max_accept_us);
      REG_SYNC_TIME:  prdata = APB_DW'(cfg.sync_time_us);
      REG_TOL_LOW:    prdata = APB_DW'(cfg.tol_low_q8);
      REG_TOL_HIGH:   prdata = APB_DW'(cfg.tol_high_q8);
      REG_PAT_LEN:    prdata = APB_DW'(cfg.pattern_length);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/pipd_store.sv
// Interval ring and pattern table with registered reads.
`timescale 1ns / 1ps
`default_nettype none

module pipd_store (
  input  wire                               clk,
  input  wire                               rst,
  input  pipd_pkg::store_req_t              req,
  output logic [pipd_pkg::INTERVAL_W-1:0]   ring_rdata,
  output logic [pipd_pkg::ENTRY_W-1:0]      pat_rdata
);
  import pipd_pkg::*;

  logic [INTERVAL_W-1:0] ring [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_valid;
  logic [ENTRY_W-1:0]    pat [MAX_PATTERN];

  // A ring entry never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid <= '0;
    end else if (req.ring_we) begin
      ring_valid[req.ring_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ring_we) begin
      ring[req.ring_waddr] <= req.ring_wdata;
    end
    if (req.pat_we) begin
      pat[req.pat_waddr] <= req.pat_wdata;
    end
    if (req.rd_en) begin
      ring_rdata <= ring_valid[req.ring_raddr] ? ring[req.ring_raddr] : '0;
      pat_rdata  <= pat[req.pat_raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/pipd_tol_unit.sv
// Shared Q8 tolerance unit: one registered product, compared against a scaled interval.
`timescale 1ns / 1ps
`default_nettype none

module pipd_tol_unit (
  input  wire                              clk,
  input  wire                              load,
  input  wire [pipd_pkg::ENTRY_W-1:0]      expected,
  input  wire [pipd_pkg::TOL_W-1:0]        factor,
  input  wire [pipd_pkg::INTERVAL_W-1:0]   interval,
  output logic                             ge,
  output logic                             le
);
  import pipd_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] scaled;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_W'(expected) * PROD_W'(factor);
    end
  end

  assign scaled = PROD_W'({interval, {Q8_SHIFT{1'b0}}});
  assign ge     = scaled >= prod;
  assign le     = scaled <= prod;

endmodule

`default_nettype wire

FILE: design/pulse_interval_pattern_detector.sv
// Top level: item sequencer for edges, scans, latch clear and pattern loads.
//
//  channel   dir   handshake            carries
//  s_*       in    s_tvalid / s_tready  one item: kind in tuser, fields in tdata
//  m_*       out   m_tvalid / m_tready  one result per item
//  apb       in    psel & penable       configuration registers at 4*index
//
// Clear and load items pass through the result step only; edge items first pass
// the store step. A scan walks each interval checked through read, low product,
// low compare and high compare, all on the one tolerance multiplier; an interval
// that already fails the low compare skips the high compare.
// Reset (rst, synchronous) clears the ring valid bits, pointers, latch and result.
// A result waits in the output register; the next item is taken meanwhile, and
// the sequencer holds its result step until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module pulse_interval_pattern_detector (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // [31:0] edge_time_us, [36:32] entry_index, [48:37] entry_time_us, rest zero
  input  wire [pipd_pkg::S_DATA_W-1:0]       s_tdata,
  // [1:0] func
  input  wire [pipd_pkg::FUNC_W-1:0]         s_tuser,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // [0] interval_stored, [1] message_ready, [2] newly_found, [7:3] match_start
  output logic [pipd_pkg::M_DATA_W-1:0]      m_tdata,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire [pipd_pkg::APB_AW-1:0]         paddr,
  input  wire [pipd_pkg::APB_DW-1:0]         pwdata,
  output logic [pipd_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);
  import pipd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EDGE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_LO   = 3'd3;
  localparam logic [2:0] S_HI   = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  cfg_t       cfg;
  store_req_t req;

  logic [2:0]            state;
  logic [TIME_W-1:0]     last_edge;
  logic [TIME_W-1:0]     gap;
  logic [RING_AW-1:0]    write_pointer;
  logic [RING_AW-1:0]    scan_start;
  logic [RING_AW-1:0]    scan_pos;
  logic [PAT_AW-1:0]     scan_idx;
  logic                  ready_latch;
  logic [RING_AW-1:0]    found_start;
  logic                  stored;
  logic                  found;

  logic [INTERVAL_W-1:0] ring_rdata;
  logic [ENTRY_W-1:0]    pat_rdata;
  logic [ENTRY_W-1:0]    expected;
  logic [TOL_W-1:0]      factor;
  logic                  tol_load;
  logic                  tol_ge;
  logic                  tol_le;

  logic                  in_xfer;
  logic                  out_free;
  logic                  gap_ok;
  logic [LEN_EFF_W-1:0]  len_eff;
  logic [PAT_AW-1:0]     last_idx;
  logic [RING_AW-1:0]    pos_inc;
  logic [RING_AW-1:0]    wp_inc;

  pipd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pipd_store u_store (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .ring_rdata (ring_rdata),
    .pat_rdata  (pat_rdata)
  );

  pipd_tol_unit u_tol (
    .clk      (clk),
    .load     (tol_load),
    .expected (expected),
    .factor   (factor),
    .interval (ring_rdata),
    .ge       (tol_ge),
    .le       (tol_le)
  );

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign gap_ok = (gap >= TIME_W'(cfg.min_accept_us)) && (gap <= TIME_W'(cfg.max_accept_us));

  // Clamp the pattern length to 1..MAX_PATTERN
  always_comb begin
    if (cfg.pattern_length == '0) begin
      len_eff = LEN_EFF_W'(1);
    end else if (32'(cfg.pattern_length) > MAX_PATTERN) begin
      len_eff = LEN_EFF_W'(MAX_PATTERN);
    end else begin
      len_eff = LEN_EFF_W'(cfg.pattern_length);
    end
  end

  assign last_idx = PAT_AW'(len_eff - LEN_EFF_W'(1));
  assign pos_inc  = (scan_pos == RING_AW'(RING_DEPTH - 1)) ? '0 : scan_pos + 1'b1;
  assign wp_inc   = (write_pointer == RING_AW'(RING_DEPTH - 1)) ? '0 : write_pointer + 1'b1;

  // Entry zero of a pattern is always the sync interval
  assign expected = (scan_idx == '0) ? ENTRY_W'(cfg.sync_time_us) : pat_rdata;
  assign factor   = (state == S_LO) ? cfg.tol_low_q8 : cfg.tol_high_q8;
  assign tol_load = (state == S_LO) || (state == S_HI);

  always_comb begin
    req.ring_we    = (state == S_EDGE) && gap_ok;
    req.ring_waddr = write_pointer;
    req.ring_wdata = gap[INTERVAL_W-1:0];
    req.pat_we     = in_xfer && (s_tuser == FN_LOAD)
                     && (32'(s_tdata[TIME_W +: INDEX_W]) < MAX_PATTERN);
    req.pat_waddr  = PAT_AW'(s_tdata[TIME_W +: INDEX_W]);
    req.pat_wdata  = s_tdata[TIME_W + INDEX_W +: ENTRY_W];
    req.rd_en      = (state == S_RD);
    req.ring_raddr = scan_pos;
    req.pat_raddr  = scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      last_edge     <= '0;
      write_pointer <= '0;
      ready_latch   <= 1'b0;
      found_start   <= '0;
      scan_start    <= '0;
      scan_pos      <= '0;
      scan_idx      <= '0;
      stored        <= 1'b0;
      found         <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            stored <= 1'b0;
            found  <= 1'b0;
            case (s_tuser)
              FN_EDGE: begin
                gap       <= s_tdata[TIME_W-1:0] - last_edge;
                last_edge <= s_tdata[TIME_W-1:0];
                state     <= S_EDGE;
              end
              FN_SCAN: begin
                scan_start <= '0;
                scan_pos   <= '0;
                scan_idx   <= '0;
                state      <= ready_latch ? S_DONE : S_RD;
              end
              FN_CLEAR: begin
                ready_latch <= 1'b0;
                state       <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_EDGE: begin
          if (gap_ok) begin
            write_pointer <= wp_inc;
            stored        <= 1'b1;
          end
          state <= S_DONE;
        end
        S_RD: begin
          state <= S_LO;
        end
        S_LO: begin
          state <= S_HI;
        end
        S_HI: begin
          if (tol_ge) begin
            state <= S_CHK;
          end else if (scan_start != RING_AW'(RING_DEPTH - 1)) begin
            // Drop this start and try the next one
            scan_start <= scan_start + 1'b1;
            scan_pos   <= scan_start + 1'b1;
            scan_idx   <= '0;
            state      <= S_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_CHK: begin
          if (!tol_le) begin
            if (scan_start != RING_AW'(RING_DEPTH - 1)) begin
              scan_start <= scan_start + 1'b1;
              scan_pos   <= scan_start + 1'b1;
              scan_idx   <= '0;
              state      <= S_RD;
            end else begin
              state <= S_DONE;
            end
          end else if (scan_idx == last_idx) begin
            ready_latch <= 1'b1;
            found_start <= scan_start;
            found       <= 1'b1;
            state       <= S_DONE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
            scan_pos <= pos_inc;
            state    <= S_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tdata <= {MATCH_W'(found_start), found, ready_latch, stored};
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A newly found pattern always reports the latch set
  a_found_latched: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1])
    else $error("newly_found without message_ready");

  // No search runs while a message is latched
  a_scan_unlatched: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_LO || state == S_HI || state == S_CHK) |-> !ready_latch)
    else $error("scan running with latch set");

  // One item at a time: ready drops after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_tready)
    else $error("second item taken while busy");

  // Walk position stays in step with start and entry index
  a_pos_in_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD && scan_idx == '0) |-> scan_pos == scan_start)
    else $error("ring position out of step with start");

  // A stored interval always advances the write pointer by one
  a_wp_step: assert property (@(posedge clk) disable iff (rst)
    req.ring_we |=> write_pointer == $past(wp_inc))
    else $error("write pointer did not advance");

endmodule

`default_nettype wire

FILE: dv/pipd_checker.sv
// Checker for the pulse interval pattern detector: tracks writes and items, predicts, compares.
`timescale 1ns / 1ps

module pipd_checker (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  input  wire                          s_tready,
  input  wire [pipd_pkg::S_DATA_W-1:0] s_tdata,
  input  wire [pipd_pkg::FUNC_W-1:0]   s_tuser,
  input  wire                          m_tvalid,
  input  wire                          m_tready,
  input  wire [pipd_pkg::M_DATA_W-1:0] m_tdata,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire                          pready,
  input  wire [pipd_pkg::APB_AW-1:0]   paddr,
  input  wire [pipd_pkg::APB_DW-1:0]   pwdata,
  output int                           mismatches,
  output int                           outstanding,
  output int                           hits
);
  import pipd_pkg::*;

  // Field order matches m_tdata from the top bit down
  typedef struct packed {
    logic [MATCH_W-1:0] start;
    logic               found;
    logic               ready;
    logic               stored;
  } outcome_t;

  cfg_t                  regs;
  logic [INTERVAL_W-1:0] gap_ring [RING_DEPTH];
  logic [RING_AW-1:0]    wr_ptr;
  logic [TIME_W-1:0]     prev_edge;
  logic [ENTRY_W-1:0]    pat_tab [MAX_PATTERN];
  logic                  latched;
  logic [MATCH_W-1:0]    hit_start;
  outcome_t              pending_q[$];
  outcome_t              want, got;

  function automatic bit in_tolerance(input logic [INTERVAL_W-1:0] t,
                                      input logic [ENTRY_W-1:0] e);
    longint unsigned scaled, lo_lim, hi_lim;
    scaled = 64'(t) << Q8_SHIFT;
    lo_lim = 64'(e) * 64'(regs.tol_low_q8);
    hi_lim = 64'(e) * 64'(regs.tol_high_q8);
    return scaled >= lo_lim && scaled <= hi_lim;
  endfunction

  function automatic bit start_hits(input int s, input int len);
    if (!in_tolerance(gap_ring[s], regs.sync_time_us)) return 1'b0;
    for (int i = 1; i < len; i++)
      if (!in_tolerance(gap_ring[(s + i) % RING_DEPTH], pat_tab[i])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic outcome_t predict_outcome(input logic [FUNC_W-1:0] fn,
                                               input logic [S_DATA_W-1:0] data);
    outcome_t r;
    logic [TIME_W-1:0] now, gap;
    int len;
    r = '0;
    case (fn)
      FN_EDGE: begin
        now = data[TIME_W-1:0];
        gap = now - prev_edge;
        prev_edge = now;
        if (gap >= regs.min_accept_us && gap <= regs.max_accept_us) begin
          gap_ring[wr_ptr] = gap[INTERVAL_W-1:0];
          wr_ptr = wr_ptr + 1'b1;
          r.stored = 1'b1;
        end
      end
      FN_SCAN: begin
        if (!latched) begin
          // clamp the length: zero means sync only
          len = regs.pattern_length;
          if (len == 0) len = 1;
          if (len > MAX_PATTERN) len = MAX_PATTERN;
          for (int s = 0; s < RING_DEPTH; s++) begin
            if (start_hits(s, len)) begin
              latched = 1'b1;
              hit_start = MATCH_W'(s);
              r.found = 1'b1;
              break;
            end
          end
        end
      end
      FN_CLEAR: latched = 1'b0;
      FN_LOAD: pat_tab[data[TIME_W +: INDEX_W]] = data[TIME_W + INDEX_W +: ENTRY_W];
      default: ;
    endcase
    r.ready = latched;
    r.start = hit_start;
    return r;
  endfunction

  task automatic note_mismatch(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
    mismatches++;
    $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs = {MIN_ACCEPT_RST, MAX_ACCEPT_RST, SYNC_TIME_RST,
              TOL_LOW_RST, TOL_HIGH_RST, PAT_LEN_RST};
      foreach (gap_ring[i]) gap_ring[i] = '0;
      foreach (pat_tab[i]) pat_tab[i] = '0;
      wr_ptr = '0;
      prev_edge = '0;
      latched = 1'b0;
      hit_start = '0;
      pending_q.delete();
      mismatches = 0;
      hits = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_MIN_ACCEPT: regs.min_accept_us  = pwdata[INTERVAL_W-1:0];
          REG_MAX_ACCEPT: regs.max_accept_us  = pwdata[INTERVAL_W-1:0];
          REG_SYNC_TIME:  regs.sync_time_us   = pwdata[SYNC_W-1:0];
          REG_TOL_LOW:    regs.tol_low_q8     = pwdata[TOL_W-1:0];
          REG_TOL_HIGH:   regs.tol_high_q8    = pwdata[TOL_W-1:0];
          REG_PAT_LEN:    regs.pattern_length = pwdata[LEN_W-1:0];
          default: ;
        endcase
      end
      // compare before pushing: a result never leaves in the cycle its item arrives
      if (m_tvalid && m_tready) begin
        got = outcome_t'(m_tdata);
        if (pending_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, expected none, got %h",
                   $time, m_tdata);
        end else begin
          want = pending_q.pop_front();
          if (got.stored !== want.stored)
            note_mismatch("interval_stored", 8'(want.stored), 8'(got.stored));
          if (got.ready !== want.ready)
            note_mismatch("message_ready", 8'(want.ready), 8'(got.ready));
          if (got.found !== want.found)
            note_mismatch("newly_found", 8'(want.found), 8'(got.found));
          if (got.start !== want.start)
            note_mismatch("match_start", 8'(want.start), 8'(got.start));
        end
      end
      if (s_tvalid && s_tready) begin
        want = predict_outcome(s_tuser, s_tdata);
        if (want.found) hits++;
        pending_q.push_back(want);
      end
    end
    outstanding <= pending_q.size();
  end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the pulse interval pattern detector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import pipd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PRESSURE_HOLD  = 300;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [FUNC_W-1:0]   s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int mismatches, outstanding, hits;

  // stimulus-side copy of the settings and the pattern table
  int unsigned cf_min, cf_max, cf_sync, cf_tl, cf_th, cf_len;
  logic [ENTRY_W-1:0] pat_val [MAX_PATTERN];
  bit   [MAX_PATTERN-1:0] pat_set;
  logic [TIME_W-1:0] last_ts;

  bit tx_gaps, rx_stalls, hold_req;
  int n_items, n_edge, n_scan, n_clear, n_load, n_settings;
  int quiet;

  pulse_interval_pattern_detector dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  pipd_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .hits        (hits)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result side: random back-pressure, plus one long hold on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (PRESSURE_HOLD) @(posedge clk);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic int unsigned eff_len();
    if (cf_len == 0) return 1;
    if (cf_len > MAX_PATTERN) return MAX_PATTERN;
    return cf_len;
  endfunction

  // Pick an interval inside the tolerance window of e that is storable, or any interval if there is none
  function automatic int unsigned good_gap(input int unsigned e);
    int unsigned lo, hi;
    lo = (e * cf_tl + 255) / 256;
    hi = (e * cf_th) / 256;
    if (lo < cf_min) lo = cf_min;
    if (hi > cf_max) hi = cf_max;
    if (lo > hi) return $urandom_range(0, 1023);
    return $urandom_range(lo, hi);
  endfunction

  function automatic int unsigned pick_entry();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 4095 : 0;
    if (cf_min <= cf_max) return $urandom_range(cf_min, cf_max);
    return $urandom_range(100, 1000);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input int unsigned mn, mx, sy, tl, th, ln);
    write_reg(REG_MIN_ACCEPT, mn);
    write_reg(REG_MAX_ACCEPT, mx);
    write_reg(REG_SYNC_TIME, sy);
    write_reg(REG_TOL_LOW, tl);
    write_reg(REG_TOL_HIGH, th);
    write_reg(REG_PAT_LEN, ln);
    cf_min = mn & 10'h3FF;
    cf_max = mx & 10'h3FF;
    cf_sync = sy & 12'hFFF;
    cf_tl = tl & 9'h1FF;
    cf_th = th & 9'h1FF;
    cf_len = ln & 6'h3F;
    n_settings++;
  endtask

  // Hold tvalid across back-to-back transfers; drop it only for an idle burst
  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [S_DATA_W-1:0] data);
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    n_items++;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_edge(input logic [TIME_W-1:0] ts);
    last_ts = ts;
    n_edge++;
    send_item(FN_EDGE, {24'd0, ts});
  endtask

  task automatic send_scan();
    n_scan++;
    send_item(FN_SCAN, {24'd0, 32'($urandom())});
  endtask

  task automatic send_clear();
    n_clear++;
    send_item(FN_CLEAR, {24'd0, 32'($urandom())});
  endtask

  task automatic send_load(input logic [INDEX_W-1:0] idx, input logic [ENTRY_W-1:0] val);
    pat_val[idx] = val;
    pat_set[idx] = 1'b1;
    n_load++;
    send_item(FN_LOAD, {7'd0, val, idx, 32'd0});
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Sync interval, then each pattern interval (now and then a broken one), then a scan and sometimes a clear
  task automatic run_sequence();
    int len;
    len = eff_len();
    send_edge(last_ts + good_gap(cf_sync));
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_edge(last_ts + $urandom_range(0, 1100));
      else send_edge(last_ts + good_gap(pat_val[i]));
    end
    send_scan();
    if ($urandom_range(0, 1) == 1) send_clear();
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 4))
      0: send_edge($urandom());
      1: send_edge(last_ts + $urandom_range(0, 1100));
      2: send_scan();
      3: send_clear();
      default: send_load($urandom_range(0, 31), $urandom_range(0, 4095));
    endcase
  endtask

  task automatic run_phase(input int budget, input bit calm);
    int stop_at;
    rx_stalls = !calm && ($urandom_range(0, 3) != 0);
    tx_gaps   = !calm && ($urandom_range(0, 3) != 0);
    // every entry a scan will read must be written first
    for (int i = 1; i < eff_len(); i++)
      if (!pat_set[i] || $urandom_range(0, 2) == 0) send_load(i, pick_entry());
    stop_at = n_items + budget;
    while (n_items < stop_at) begin
      if ($urandom_range(0, 9) < 7) run_sequence();
      else noise_item();
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    last_ts = '0;
    pat_set = '0;
    cf_min = MIN_ACCEPT_RST;
    cf_max = MAX_ACCEPT_RST;
    cf_sync = SYNC_TIME_RST;
    cf_tl = TOL_LOW_RST;
    cf_th = TOL_HIGH_RST;
    cf_len = PAT_LEN_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    send_load(0, 12'hFFF);
    send_load(31, 0);
    for (int i = 1; i < 8; i++) send_load(i, 100 + 100 * i);
    send_scan();                          // empty ring: no hit
    send_edge(32'hFFFF_FFFF);             // huge interval, not stored
    send_edge(32'h0000_01F3);             // wraps past zero: sync of 500
    for (int i = 1; i < 8; i++) send_edge(last_ts + 100 + 100 * i);
    send_scan();                          // hit at start zero
    send_scan();                          // latched: nothing searched
    send_clear();
    send_edge(last_ts + 99);              // just below minimum
    send_edge(last_ts + 1000);            // maximum
    send_edge(last_ts + 1001);            // just above maximum
    send_edge(last_ts + 100);             // minimum
    send_scan();
    drain();

    // Random part over a spread of settings
    apply_settings(100, 1000, 500, 205, 307, 8);
    hold_req = 1'b1;
    run_phase(150, 1'b0);
    apply_settings(0, 1023, 4095, 0, 511, 32);
    run_phase(100, 1'b0);
    apply_settings(600, 200, 500, 205, 307, 0);   // minimum above maximum, length zero
    run_phase(80, 1'b0);
    apply_settings(100, 900, 300, 256, 256, 63);  // exact match, length beyond table
    run_phase(100, 1'b0);
    apply_settings(1023, 1023, 1023, 511, 0, 1);  // empty tolerance window
    run_phase(60, 1'b0);
    apply_settings(0, 0, 0, 0, 0, 33);
    run_phase(60, 1'b0);
    for (int p = 0; p < 6; p++) begin
      apply_settings($urandom_range(0, 400), $urandom_range(400, 1023),
                     $urandom_range(100, 1000), $urandom_range(150, 256),
                     $urandom_range(256, 400),
                     $urandom_range(0, 4) == 0 ? $urandom_range(13, 32) : $urandom_range(1, 12));
      run_phase(130, p == 5);
    end

    $display("Sent %0d items: %0d edges, %0d scans, %0d clears, %0d loads, over %0d settings",
             n_items, n_edge, n_scan, n_clear, n_load, n_settings);
    $display("Pattern hits predicted and checked: %0d", hits);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
